>>> src/mexp_pkg.sv
// package for the modular exponentiation block
// widths, register map and sequencer state type; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;
    localparam int MOD_WIDTH   = 31;
    localparam int FIELD_WIDTH = 63;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_WIDTH  = 3;
    localparam int RCNT_WIDTH  = $clog2(FIELD_WIDTH);
    localparam int MCNT_WIDTH  = $clog2(MOD_WIDTH);

    localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;
    localparam logic                 REG_MODULUS   = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_MUL    = 5'b01000,
        S_SQR    = 5'b10000
    } t_state;
endpackage
`default_nettype wire

>>> src/mexp_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none
module mexp_modmul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mexp_pkg::MOD_WIDTH-1:0] i_a,
    input  wire logic [mexp_pkg::MOD_WIDTH-1:0] i_b,
    input  wire logic [mexp_pkg::MOD_WIDTH-1:0] i_mod,
    output logic                               o_done,
    output logic [mexp_pkg::MOD_WIDTH-1:0]     o_product
);
    import mexp_pkg::*;

    logic [MOD_WIDTH-1:0]  r_acc, n_acc;
    logic [MOD_WIDTH-1:0]  r_b;
    logic [MCNT_WIDTH-1:0] r_cnt;
    logic                  r_run;
    logic                  r_done;
    logic [MOD_WIDTH:0]    w_dbl;
    logic [MOD_WIDTH:0]    w_sum;
    logic [MOD_WIDTH-1:0]  w_dbl_red;

    // double then add, each followed by one conditional subtract
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, i_mod}) ? MOD_WIDTH'(w_dbl - {1'b0, i_mod})
                                              : w_dbl[MOD_WIDTH-1:0];
        w_sum     = {1'b0, w_dbl_red} + (r_b[MOD_WIDTH-1] ? {1'b0, i_a} : '0);
        n_acc     = (w_sum >= {1'b0, i_mod}) ? MOD_WIDTH'(w_sum - {1'b0, i_mod})
                                              : w_sum[MOD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= MCNT_WIDTH'(MOD_WIDTH - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_b   <= i_b;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MOD_WIDTH-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run)) else $error("product strobe without a running multiply");
    a_product_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_acc < i_mod) else $error("product not reduced");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_start) else $error("multiply restarted while running");
endmodule
`default_nettype wire

>>> src/modular_exponentiation.sv
// modular exponentiation top level: apb modulus register, base reduction, square-and-multiply
// depends on mexp_pkg and mexp_modmul
`timescale 1ns / 1ps
`default_nettype none
// A transaction is taken when start is high and busy is low; o_done is high for a single
// cycle with the result on o_power_result and cannot be held off. The base is first reduced
// one bit per cycle, then each exponent bit up to the highest set one costs a square and,
// when set, a multiply, each done by the shared bit-serial modular multiplier. A zero
// exponent gives 1 for every modulus; a modulus of zero behaves like a modulus of one.
module modular_exponentiation (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] i_base_value,
    input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] i_exponent,
    output logic                                 o_done,
    output logic [mexp_pkg::MOD_WIDTH-1:0]       o_power_result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mexp_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [mexp_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [mexp_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                 pready
);
    import mexp_pkg::*;

    t_state                 r_state;
    logic [MOD_WIDTH-1:0]   r_modulus;
    logic [MOD_WIDTH-1:0]   w_mod;
    logic [FIELD_WIDTH-1:0] r_base;
    logic [FIELD_WIDTH-1:0] r_exp;
    logic [RCNT_WIDTH-1:0]  r_cnt;
    logic [MOD_WIDTH-1:0]   r_sq, n_sq_red;
    logic [MOD_WIDTH-1:0]   r_acc;
    logic                   r_mm_start;
    logic                   r_done;
    logic [MOD_WIDTH-1:0]   r_result;
    logic [MOD_WIDTH:0]     w_shift;
    logic                   w_mm_done;
    logic [MOD_WIDTH-1:0]   w_mm_a;
    logic [MOD_WIDTH-1:0]   w_product;
    logic                   w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
    assign prdata   = (paddr[2] == REG_MODULUS) ? {1'b0, r_modulus} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (w_cfg_wr) begin
            r_modulus <= pwdata[MOD_WIDTH-1:0];
        end
    end

    assign w_mod = (r_modulus == '0) ? MOD_WIDTH'(1) : r_modulus;

    // base reduction step: shift in one base bit, subtract once
    always_comb begin
        w_shift  = {r_sq, r_base[FIELD_WIDTH-1]};
        n_sq_red = (w_shift >= {1'b0, w_mod}) ? MOD_WIDTH'(w_shift - {1'b0, w_mod})
                                               : w_shift[MOD_WIDTH-1:0];
    end

    assign w_mm_a = (r_state == S_MUL) ? r_acc : r_sq;

    mexp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mm_start),
        .i_a       (w_mm_a),
        .i_b       (r_sq),
        .i_mod     (w_mod),
        .o_done    (w_mm_done),
        .o_product (w_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mm_start <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            r_done     <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (r_cnt == '0) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_exp == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_mm_start <= 1'b1;
                        r_state    <= r_exp[0] ? S_MUL : S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_mm_done) begin
                        r_mm_start <= 1'b1;
                        r_state    <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_mm_done) begin
                        r_state <= S_CHECK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_base <= i_base_value;
                r_exp  <= i_exponent;
                r_cnt  <= RCNT_WIDTH'(FIELD_WIDTH - 1);
                r_sq   <= '0;
                r_acc  <= MOD_WIDTH'(1);
            end
            S_REDUCE: begin
                r_sq   <= n_sq_red;
                r_base <= {r_base[FIELD_WIDTH-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_CHECK: begin
                r_result <= r_acc;
            end
            S_MUL: begin
                if (w_mm_done) begin
                    r_acc <= w_product;
                end
            end
            S_SQR: begin
                if (w_mm_done) begin
                    r_sq  <= w_product;
                    r_exp <= {1'b0, r_exp[FIELD_WIDTH-1:1]};
                end
            end
            default: ;
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_power_result = r_result;

    a_done_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_CHECK)) else $error("result strobe outside check step");
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && w_mod != MOD_WIDTH'(1)) |-> r_result < w_mod)
        else $error("result not reduced");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction did not start");
    a_mm_only_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_done |-> (r_state == S_MUL || r_state == S_SQR))
        else $error("multiplier finished outside a multiply step");
endmodule
`default_nettype wire
